@@ sv/arct_pkg.sv @@
// Package: widths, mode and read-kind codes for the address region table classifier.
`default_nettype none

package arct_pkg;

   localparam int ADDR_W  = 64;
   localparam int COUNT_W = 64;
   localparam int MODE_W  = 2;
   localparam int KIND_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_REGISTER   = 2'd0,
      MODE_UNREGISTER = 2'd1,
      MODE_CLASSIFY   = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_COLD    = 2'd0,
      KIND_SPECIAL = 2'd1,
      KIND_PADDING = 2'd2,
      KIND_OOB     = 2'd3
   } read_kind_type;

   localparam int KIND_COUNT = 4;

endpackage

`default_nettype wire

@@ sv/arct_req_if.sv @@
// Request channel: valid/ready handshake carrying one request item.
`default_nettype none

interface arct_req_if;
   import arct_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ADDR_W-1:0]   address;
   logic [ADDR_W-1:0]   size;
   logic [ADDR_W-1:0]   used_size;
   logic                region_kind;
   logic [ADDR_W-1:0]   owner_id;

   modport source (output valid, output mode, output address, output size,
                   output used_size, output region_kind, output owner_id,
                   input ready);
   modport sink   (input valid, input mode, input address, input size,
                   input used_size, input region_kind, input owner_id,
                   output ready);
endinterface

`default_nettype wire

@@ sv/arct_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result item.
`default_nettype none

interface arct_rsp_if;
   import arct_pkg::*;

   logic                valid;
   logic                ready;
   logic                ok;
   logic [KIND_W-1:0]   read_kind;
   logic [COUNT_W-1:0]  kind_count;

   modport source (output valid, output ok, output read_kind, output kind_count,
                   input ready);
   modport sink   (input valid, input ok, input read_kind, input kind_count,
                   output ready);
endinterface

`default_nettype wire

@@ sv/address_region_table_classifier_core.sv @@
// Top level: region table with register, unregister and classify requests.
`default_nettype none

// The block keeps up to REGION_SLOTS non-overlapping address regions and answers
// every request item with exactly one result item. An accepted item lands in an
// input register; from there all slots are compared against it in parallel and,
// once the result register is free or being drained, the table and miss counters
// are updated and the result is captured in an output register. One item is
// taken per cycle as long as results are drained; a held result only stalls the
// input once both registers are occupied. The achievable clock rate is set by the
// single slot-compare stage between the input and result registers, whose depth
// grows with REGION_SLOTS (wide compares per slot plus a lowest-slot priority
// pick). Each slot stores its base, end and requested end, so no per-slot add
// sits in the compare path. Register with a base already present succeeds only
// for an identical entry; mode 3 answers ok = 0 and changes nothing.
module address_region_table_classifier_core #(
   parameter int REGION_SLOTS = 16
) (
   input  wire         clock,
   input  wire         reset,
   arct_req_if.sink    req,
   arct_rsp_if.source  rsp
);
   import arct_pkg::*;

   localparam logic [REGION_SLOTS-1:0] SLOT_ONE = REGION_SLOTS'(1);

   // input register
   logic                in_valid_ff;
   mode_type            in_mode_ff;
   logic [ADDR_W-1:0]   in_addr_ff;
   logic [ADDR_W-1:0]   in_size_ff;
   logic [ADDR_W-1:0]   in_req_ff;
   logic                in_special_ff;
   logic [ADDR_W-1:0]   in_owner_ff;

   // region table
   logic [REGION_SLOTS-1:0] slot_valid_ff;
   logic [REGION_SLOTS-1:0] slot_valid_in;
   logic [ADDR_W-1:0]       slot_base_ff    [REGION_SLOTS];
   logic [ADDR_W-1:0]       slot_end_ff     [REGION_SLOTS];
   logic [ADDR_W-1:0]       slot_req_end_ff [REGION_SLOTS];
   logic [REGION_SLOTS-1:0] slot_special_ff;
   logic [ADDR_W-1:0]       slot_owner_ff   [REGION_SLOTS];

   // miss counters, one per read kind
   logic [COUNT_W-1:0] miss_count_ff [KIND_COUNT];

   // result register
   logic                out_valid_ff;
   logic                out_ok_ff;
   logic                out_ok_in;
   read_kind_type       out_kind_ff;
   read_kind_type       out_kind_in;
   logic [COUNT_W-1:0]  out_count_ff;
   logic [COUNT_W-1:0]  out_count_in;

   // datapath
   logic                advance;
   logic [ADDR_W:0]     span_sum;
   logic [ADDR_W-1:0]   span_end;
   logic                span_ok;
   logic [ADDR_W-1:0]   req_end;
   logic                sizes_ok;
   logic [REGION_SLOTS-1:0] base_hit;
   logic [REGION_SLOTS-1:0] same_entry;
   logic [REGION_SLOTS-1:0] overlap;
   logic [REGION_SLOTS-1:0] contain;
   logic [REGION_SLOTS-1:0] contain_first;
   logic [REGION_SLOTS-1:0] free_first;
   logic [REGION_SLOTS-1:0] owner_hit;
   logic                sel_special;
   logic [ADDR_W-1:0]   sel_req_end;
   logic                wr_en;
   logic                cnt_en;

   // handshake: advance when a result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign rsp.valid      = out_valid_ff;
   assign rsp.ok         = out_ok_ff;
   assign rsp.read_kind  = out_kind_ff;
   assign rsp.kind_count = out_count_ff;

   // span of the request: carry out means the end reaches 2^64
   assign span_sum = {1'b0, in_addr_ff} + {1'b0, in_size_ff};
   assign span_end = span_sum[ADDR_W-1:0];
   assign span_ok  = (in_size_ff != '0) && !span_sum[ADDR_W];
   assign req_end  = in_addr_ff + in_req_ff;
   assign sizes_ok = (in_req_ff != '0) && (in_size_ff >= in_req_ff) && span_ok;

   // compare every slot against the request
   always_comb begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
         base_hit[i]   = slot_valid_ff[i] && (slot_base_ff[i] == in_addr_ff);
         same_entry[i] = (slot_end_ff[i] == span_end) && (slot_req_end_ff[i] == req_end) &&
                         (slot_special_ff[i] == in_special_ff) &&
                         (slot_owner_ff[i] == in_owner_ff);
         owner_hit[i]  = base_hit[i] && (slot_owner_ff[i] == in_owner_ff);
         overlap[i]    = slot_valid_ff[i] && (slot_base_ff[i] < span_end) &&
                         (in_addr_ff < slot_end_ff[i]);
         contain[i]    = slot_valid_ff[i] && (slot_base_ff[i] <= in_addr_ff) &&
                         (span_end <= slot_end_ff[i]);
      end
   end

   // pick lowest free slot and lowest containing slot
   assign free_first    = ~slot_valid_ff & (slot_valid_ff + SLOT_ONE);
   assign contain_first = contain & (~contain + SLOT_ONE);

   // select the containing slot's kind and requested end
   always_comb begin
      sel_special = 1'b0;
      sel_req_end = '0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         sel_special = sel_special | (contain_first[i] & slot_special_ff[i]);
         sel_req_end = sel_req_end | ({ADDR_W{contain_first[i]}} & slot_req_end_ff[i]);
      end
   end

   // decide the result, table update and counter bump
   always_comb begin
      out_ok_in     = 1'b0;
      out_kind_in   = KIND_COLD;
      out_count_in  = '0;
      slot_valid_in = slot_valid_ff;
      wr_en         = 1'b0;
      cnt_en        = 1'b0;
      case (in_mode_ff)
         MODE_REGISTER: begin
            if (sizes_ok) begin
               if (|base_hit) begin
                  out_ok_in = |(base_hit & same_entry);
               end else if (!(|overlap) && (|free_first)) begin
                  out_ok_in     = 1'b1;
                  wr_en         = 1'b1;
                  slot_valid_in = slot_valid_ff | free_first;
               end
            end
         end
         MODE_UNREGISTER: begin
            out_ok_in     = |owner_hit;
            slot_valid_in = slot_valid_ff & ~owner_hit;
         end
         MODE_CLASSIFY: begin
            cnt_en = 1'b1;
            if (!span_ok || !(|contain)) begin
               out_kind_in = KIND_OOB;
            end else if (sel_special) begin
               out_kind_in = KIND_SPECIAL;
            end else if (span_end > sel_req_end) begin
               out_kind_in = KIND_PADDING;
            end else begin
               out_kind_in = KIND_COLD;
            end
            out_ok_in    = (out_kind_in != KIND_OOB);
            out_count_in = miss_count_ff[out_kind_in] + COUNT_W'(1);
         end
         default: begin
            out_ok_in = 1'b0;
         end
      endcase
   end

   // control state: handshake flags, slot valid bits, counters
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         for (int k = 0; k < KIND_COUNT; k++) begin
            miss_count_ff[k] <= '0;
         end
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff  <= 1'b1;
            slot_valid_ff <= slot_valid_in;
            if (cnt_en) begin
               miss_count_ff[out_kind_in] <= out_count_in;
            end
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // capture the incoming item
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_mode_ff    <= mode_type'(req.mode);
         in_addr_ff    <= req.address;
         in_size_ff    <= req.size;
         in_req_ff     <= req.used_size;
         in_special_ff <= req.region_kind;
         in_owner_ff   <= req.owner_id;
      end
   end

   // hold the result item
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ok_ff    <= out_ok_in;
         out_kind_ff  <= out_kind_in;
         out_count_ff <= out_count_in;
      end
   end

   // write a new region into the lowest free slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (advance && wr_en && free_first[i]) begin
            slot_base_ff[i]    <= in_addr_ff;
            slot_end_ff[i]     <= span_end;
            slot_req_end_ff[i] <= req_end;
            slot_special_ff[i] <= in_special_ff;
            slot_owner_ff[i]   <= in_owner_ff;
         end
      end
   end

endmodule

`default_nettype wire
